FILE: rtl/cai_pkg.sv
// Types and constants shared by the crane alarm interlock.
// No dependencies; imported by cai_eval and crane_alarm_interlock.
package cai_pkg;

    localparam int TS_W     = 48;
    localparam int SETTLE_W = 20;
    localparam int CFG_W    = 20;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_SILENCE   = 3'd1;
    localparam logic [2:0] OP_HORN_TEST = 3'd2;
    localparam logic [2:0] OP_LAMP_TEST = 3'd3;
    localparam logic [2:0] OP_FORCE_OFF = 3'd4;
    localparam logic [2:0] OP_RESUME    = 3'd5;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_REF_FORCED = 2'd1;
    localparam logic [1:0] ST_REF_HW_DIS = 2'd2;

    localparam logic CFG_SETTLE = 1'b0;
    localparam logic CFG_HW_EN  = 1'b1;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [TS_W-1:0] now_ms;
        logic            motion_ok;
        logic            moving_flag;
        logic            hook_raw;
        logic            helmet_raw;
        logic            intrusion_raw;
    } t_item;

    typedef struct packed {
        logic       lamp_cmd;
        logic       horn_cmd;
        logic       hook_event;
        logic       intrusion_event;
        logic       helmet_event;
        logic [1:0] status;
        logic       horn_test_state;
        logic       lamp_test_state;
    } t_result;

    typedef struct packed {
        logic            started;
        logic            moving_mode;
        logic [TS_W-1:0] ready_at;
        logic            prev_hook;
        logic            prev_intrusion;
        logic            prev_helmet;
        logic            silenced;
        logic            forced_off;
        logic            auto_horn;
        logic            horn_test;
        logic            lamp_test;
        logic            applied_lamp;
        logic            applied_horn;
    } t_state;

endpackage

FILE: rtl/cai_eval.sv
// Next-state and result logic for one beat of the crane alarm interlock.
// Depends on cai_pkg.
module cai_eval (
    input  cai_pkg::t_state                  i_state,
    input  cai_pkg::t_item                   i_item,
    input  logic [cai_pkg::SETTLE_W-1:0]     i_settle_dly,
    input  logic                             i_hw_en,
    output cai_pkg::t_state                  o_state,
    output cai_pkg::t_result                 o_result
);
    import cai_pkg::*;

    logic [TS_W:0]   sum;
    logic [TS_W-1:0] deadline;
    logic            moving;
    logic            mode_chg;
    logic [TS_W-1:0] ready_at_t;
    logic            ready;
    logic            helm;
    logic            intr;
    logic            sil;
    logic            lamp_on;
    logic            lamp_flip;
    logic            auto_h;
    logic            horn_on;

    // Saturate the settle deadline at the top of the timestamp range
    assign sum      = {1'b0, i_item.now_ms} + {{(TS_W + 1 - SETTLE_W){1'b0}}, i_settle_dly};
    assign deadline = sum[TS_W] ? {TS_W{1'b1}} : sum[TS_W-1:0];

    // Tick path
    always_comb begin
        moving     = i_item.motion_ok & i_item.moving_flag;
        mode_chg   = !i_state.started || (i_state.moving_mode != moving);
        ready_at_t = mode_chg ? deadline : i_state.ready_at;
        ready      = i_item.now_ms >= ready_at_t;
        helm       = !moving && ready && !i_state.lamp_test && i_item.helmet_raw;
        intr       = moving && ready && i_item.intrusion_raw;
        sil        = i_state.silenced;
        if (i_state.silenced && !i_state.forced_off && !i_item.hook_raw && !helm && !intr) begin
            sil = 1'b0;
        end
        lamp_on   = !i_state.forced_off && (moving || i_state.lamp_test);
        lamp_flip = lamp_on != i_state.applied_lamp;
        // A lamp switch restarts settling and masks the camera alarms
        if (lamp_flip) begin
            ready_at_t = deadline;
            helm       = 1'b0;
            intr       = 1'b0;
            auto_h     = !i_state.forced_off && !sil && i_item.hook_raw;
        end else begin
            auto_h     = !sil && (i_item.hook_raw || helm || intr);
        end
        horn_on = !i_state.forced_off && (auto_h || i_state.horn_test);
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.status = ST_DONE;
        case (i_item.opcode)
            OP_TICK: begin
                o_state.started        = 1'b1;
                o_state.moving_mode    = moving;
                o_state.ready_at       = ready_at_t;
                o_state.silenced       = sil;
                o_state.auto_horn      = auto_h;
                o_state.applied_lamp   = lamp_on;
                o_state.applied_horn   = horn_on;
                o_state.prev_hook      = i_item.hook_raw;
                o_state.prev_intrusion = intr;
                o_state.prev_helmet    = helm;
                o_result.hook_event      = i_item.hook_raw && !i_state.prev_hook;
                o_result.intrusion_event = intr && !i_state.prev_intrusion;
                o_result.helmet_event    = helm && !i_state.prev_helmet;
            end
            OP_SILENCE: begin
                o_state.silenced     = 1'b1;
                o_state.auto_horn    = 1'b0;
                o_state.horn_test    = 1'b0;
                o_state.applied_lamp = !i_state.forced_off &&
                                       (i_state.moving_mode || i_state.lamp_test);
                o_state.applied_horn = 1'b0;
            end
            OP_HORN_TEST, OP_LAMP_TEST: begin
                if (i_state.forced_off) begin
                    o_result.status = ST_REF_FORCED;
                end else if (!i_hw_en) begin
                    o_result.status = ST_REF_HW_DIS;
                end else begin
                    if (i_item.opcode == OP_HORN_TEST) begin
                        o_state.horn_test = !i_state.horn_test;
                    end else begin
                        o_state.lamp_test = !i_state.lamp_test;
                        o_state.ready_at  = deadline;
                    end
                    o_state.applied_lamp = i_state.moving_mode || o_state.lamp_test;
                    o_state.applied_horn = i_state.auto_horn || o_state.horn_test;
                end
            end
            OP_FORCE_OFF: begin
                o_state.forced_off   = 1'b1;
                o_state.silenced     = 1'b1;
                o_state.auto_horn    = 1'b0;
                o_state.horn_test    = 1'b0;
                o_state.lamp_test    = 1'b0;
                o_state.applied_lamp = 1'b0;
                o_state.applied_horn = 1'b0;
            end
            OP_RESUME: begin
                o_state.forced_off   = 1'b0;
                o_state.silenced     = 1'b0;
                o_state.auto_horn    = 1'b0;
                o_state.horn_test    = 1'b0;
                o_state.lamp_test    = 1'b0;
                o_state.ready_at     = deadline;
                o_state.applied_lamp = i_state.moving_mode;
                o_state.applied_horn = 1'b0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.lamp_cmd        = o_state.applied_lamp;
        o_result.horn_cmd        = o_state.applied_horn;
        o_result.horn_test_state = o_state.horn_test;
        o_result.lamp_test_state = o_state.lamp_test;
    end

endmodule

FILE: rtl/crane_alarm_interlock.sv
// Crane alarm interlock: lamp and horn control with alarm gating and events.
// Input beats carry a tick or an operator command; each gives one result beat.
// A beat passes the input register, then the result register, to become a
// result beat. Throughput: one beat per cycle unless i_stall holds it; the
// interlock state is updated as the item leaves the input register, so
// back-to-back beats see the state left by the one before.
// Handshake: a beat moves when valid is high and stall is low. o_stall rises
// only while both the input register and the result register are full and
// i_stall is high; a waiting result holds its payload.
// Configuration: i_cfg_we writes the settle delay (index 0) or the hardware
// enable (index 1) from i_cfg_data; write only while no beat is in flight.
// Reset (synchronous, active low) empties both registers and clears all
// interlock state and configuration to zero.
// Depends on cai_pkg and cai_eval.
module crane_alarm_interlock (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cai_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cai_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cai_pkg::CFG_W-1:0]     i_cfg_data
);
    import cai_pkg::*;

    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    t_result             r_out;
    t_state              r_state;
    t_state              n_state;
    t_result             n_out;
    logic [SETTLE_W-1:0] r_settle_dly;
    logic                r_hw_en;
    logic                adv;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    cai_eval u_eval (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_settle_dly (r_settle_dly),
        .i_hw_en      (r_hw_en),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_dly <= '0;
            r_hw_en      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETTLE: r_settle_dly <= i_cfg_data[SETTLE_W-1:0];
                CFG_HW_EN:  r_hw_en      <= i_cfg_data[0];
                default:    r_hw_en      <= r_hw_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_item;
        end
    end

    // Commit state and load the result as the beat leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule
